[rtl/core/tcc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor controller.
// ---------------------------------------------------------------------------
package tcc_pkg;

	localparam int COL_W   = 6;
	localparam int ROW_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 6;
	localparam int IDX_W   = 2;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 24;

	localparam logic [CFG_W-1:0] COLUMNS_RST = 6'd40;
	localparam logic [CFG_W-1:0] ROWS_RST    = 6'd25;
	localparam logic [CFG_W-1:0] ROWS_MAX    = 6'd32;

	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	typedef enum logic [OP_W-1:0] {
		OP_PRINT = 2'd0,
		OP_SETPOS = 2'd1,
		OP_HOME = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_COLUMNS = 2'd0,
		REG_ROWS = 2'd1,
		REG_ENABLED = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic set_pos;
		logic home;
		logic ret;
		logic tab_step;
		logic col_inc;
		logic next_line;
		logic latch_char;
		logic emit_char;
		logic emit_clear;
	} cmd_t;

	typedef struct packed {
		logic is_set;
		logic is_home;
		logic is_print;
		logic is_ret;
		logic is_nl;
		logic is_tab;
		logic tab_wrap;
		logic char_wrap;
		logic cols_zero;
		logic clr_last;
		logic slot_free;
	} status_t;

endpackage

[rtl/core/tcc_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: decodes each item and steps the cell-write and line-clear runs.
// ---------------------------------------------------------------------------
module tcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  tcc_pkg::status_t  status,
	output tcc_pkg::cmd_t     cmd
);
	import tcc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAR,
		ST_CLEAR
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					if (status.is_set) begin
						cmd.set_pos = 1'b1;
					end else if (status.is_home) begin
						cmd.home = 1'b1;
					end else if (status.is_print) begin
						if (status.is_ret) begin
							cmd.ret = 1'b1;
						end else if (status.is_nl || (status.is_tab && status.tab_wrap)) begin
							cmd.next_line = 1'b1;
							if (!status.cols_zero)
								state_nxt = ST_CLEAR;
						end else if (status.is_tab) begin
							cmd.tab_step = 1'b1;
						end else begin
							cmd.latch_char = 1'b1;
							state_nxt = ST_CHAR;
						end
					end
				end
			end
			ST_CHAR: begin
				if (status.slot_free) begin
					cmd.emit_char = 1'b1;
					if (status.char_wrap) begin
						cmd.next_line = 1'b1;
						state_nxt = status.cols_zero ? ST_IDLE : ST_CLEAR;
					end else begin
						cmd.col_inc = 1'b1;
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				if (status.slot_free) begin
					cmd.emit_clear = 1'b1;
					if (status.clr_last)
						state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/core/tcc_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_datapath
// Cursor, settings, line-clear counter and the output beat register.
// ---------------------------------------------------------------------------
module tcc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]   cfg_data,
	input  logic [tcc_pkg::OP_W-1:0]    in_op,
	input  logic [tcc_pkg::IN_W-1:0]    in_data,
	input  tcc_pkg::cmd_t               cmd,
	output tcc_pkg::status_t            status,
	input  logic                        m_ready,
	output logic                        m_valid,
	output logic [tcc_pkg::OUT_W-1:0]   m_data,
	output logic                        m_last
);
	import tcc_pkg::*;

	logic [CFG_W-1:0]  columns_q;
	logic [CFG_W-1:0]  rows_q;
	logic              enabled_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CHAR_W-1:0] char_q;
	logic [COL_W-1:0]  clr_q;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic [CHAR_W-1:0] in_char;
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic [CFG_W-1:0]  eff_rows;
	logic [COL_W:0]    tab_x;
	logic [COL_W:0]    inc_x;
	logic [CFG_W-1:0]  row_inc;
	logic [ROW_W-1:0]  row_adv;
	logic [COL_W:0]    clr_inc;

	assign in_char = in_data[7:0];
	assign in_col  = in_data[13:8];
	assign in_row  = in_data[18:14];

	assign eff_rows = (rows_q > ROWS_MAX) ? ROWS_MAX : rows_q;
	assign tab_x    = ({1'b0, col_q} + 7'd4) & ~7'd3;
	assign inc_x    = {1'b0, col_q} + 7'd1;
	assign row_inc  = {1'b0, row_q} + 6'd1;
	assign row_adv  = (row_inc >= eff_rows) ? '0 : row_inc[ROW_W-1:0];
	assign clr_inc  = {1'b0, clr_q} + 7'd1;

	always_comb begin
		status           = '0;
		status.is_set    = (in_op == OP_SETPOS);
		status.is_home   = (in_op == OP_HOME);
		status.is_print  = (in_op == OP_PRINT) && enabled_q;
		status.is_ret    = (in_char == CH_RETURN);
		status.is_nl     = (in_char == CH_NEWLINE);
		status.is_tab    = (in_char == CH_TAB);
		status.tab_wrap  = (tab_x >= {1'b0, columns_q});
		status.char_wrap = (inc_x >= {1'b0, columns_q});
		status.cols_zero = (columns_q == '0);
		status.clr_last  = (clr_inc == {1'b0, columns_q});
		status.slot_free = !out_valid_q || m_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data;
				REG_ROWS:    rows_q    <= cfg_data;
				REG_ENABLED: enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cmd.set_pos) begin
				if (in_col < columns_q)
					col_q <= in_col;
				if ({1'b0, in_row} < eff_rows)
					row_q <= in_row;
			end
			if (cmd.home) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.ret)
				col_q <= '0;
			if (cmd.tab_step)
				col_q <= tab_x[COL_W-1:0];
			if (cmd.col_inc)
				col_q <= inc_x[COL_W-1:0];
			if (cmd.next_line) begin
				col_q <= '0;
				row_q <= row_adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_char)
			char_q <= in_char;
		if (cmd.next_line)
			clr_q <= '0;
		else if (cmd.emit_clear)
			clr_q <= clr_inc[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_char || cmd.emit_clear) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_char) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_char_q <= char_q;
			out_last_q <= !status.char_wrap || status.cols_zero;
		end else if (cmd.emit_clear) begin
			out_col_q  <= clr_q;
			out_row_q  <= row_q;
			out_char_q <= CH_SPACE;
			out_last_q <= status.clr_last;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {5'd0, out_char_q, out_row_q, out_col_q};
	assign m_last  = out_last_q;

endmodule

[rtl/core/text_console_cursor_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_cursor_top
// Text console cursor controller: turns print, set-position and home
// commands into a stream of character cell writes.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser holds the operation, tdata the
//   character and the requested column and row. m_axis carries one cell write
//   per beat, tlast marking the final write caused by a command.
//   cfg_we/cfg_index/cfg_data write columns, rows and enabled; write them only
//   while no command is in flight.
// Timing:
//   Cursor commands, return, and tabs within the row complete as they are
//   accepted. A printable character is accepted first, then its cell write is
//   loaded into the output register. A row advance adds one clearing write per
//   column. The single output register and the sequencer limit the rate to one
//   beat per cycle while m_axis_tready is high; the first beat is loaded from
//   the ST_CHAR or ST_CLEAR state after the command is taken.
// Reset: cursor at column 0, row 0; 40 columns, 25 rows, printing disabled.
// Stall: while m_axis_tready is low the output beat holds and the sequencer
//   waits; s_axis_tready stays low until the current command has been fully
//   loaded into the output register.
// ---------------------------------------------------------------------------
module text_console_cursor_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [7:0] char_code, [13:8] new_col, [18:14] new_row, [23:19] zero
	input  logic [tcc_pkg::IN_W-1:0]    s_axis_tdata,
	// [1:0] operation
	input  logic [tcc_pkg::OP_W-1:0]    s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [5:0] cell_col, [10:6] cell_row, [18:11] cell_char, [23:19] zero
	output logic [tcc_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic                        m_axis_tlast
);
	import tcc_pkg::*;

	cmd_t    cmd;
	status_t status;

	tcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	tcc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_ready   (m_axis_tready),
		.m_valid   (m_axis_tvalid),
		.m_data    (m_axis_tdata),
		.m_last    (m_axis_tlast)
	);

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_char || cmd.emit_clear) |-> status.slot_free)
		else $error("cell write loaded over a pending beat");

	a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !(cmd.emit_char || cmd.emit_clear))
		else $error("cell write issued while taking a command");

	a_clear_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_clear && status.clr_last) |=> s_axis_tready)
		else $error("sequencer not idle after final clearing write");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_char || cmd.emit_clear) |=> m_axis_tvalid)
		else $error("loaded cell write not presented");

endmodule
